/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FTPR_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FTPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ftpr_pkg.sv */
// Types, constants and helpers for the FTP reply framer.
package ftpr_pkg;

  localparam int unsigned PrefixLen = 3;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned CodeW     = PrefixLen * DigitW;
  localparam int unsigned CntW      = $clog2(PrefixLen + 1);

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChHyphen = 8'h2d;
  localparam logic [7:0] ChNl     = 8'h0a;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_LINE  = 2'd1,
    PH_SKIP  = 2'd2,
    PH_END   = 2'd3
  } phase_e;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

endpackage

/* rtl/core/ftpr_rx_if.sv */
// Valid/ready channel carrying one received control-connection byte per beat.
interface ftpr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/core/ftpr_reply_if.sv */
// Valid/ready channel carrying one per-byte framing status beat.
interface ftpr_reply_if;
  logic                  valid;
  logic                  ready;
  ftpr_pkg::status_e     status;
  logic [3:0]            code_hundreds;
  logic [3:0]            code_tens;
  logic [3:0]            code_units;
  logic                  is_multiline;

  modport source (output valid, output status, output code_hundreds, output code_tens,
                  output code_units, output is_multiline, input ready);
  modport sink   (input valid, input status, input code_hundreds, input code_tens,
                  input code_units, input is_multiline, output ready);
endinterface

/* rtl/core/ftp_reply_framer.sv */
// FTP reply framer: per-byte status of control-connection reply framing.
//
// rx_i takes one byte of the control stream per beat. For every byte
// accepted, reply_o gives exactly one beat: status busy while a reply is in
// progress, done on the newline that closes a reply, error on the fourth
// byte of a malformed opening line, plus the reply code digits and the
// multi-line flag captured so far (all zero on an error beat).
// Each rx_i beat passes through an input register, then the framing state
// update feeding the result register, before it appears as its reply_o beat.
// Throughput is one byte per cycle while reply_o is not stalled; the framing
// state is a few byte compares and a 12-bit code compare between the two registers.
// When reply_o is stalled both stages hold and rx_i.ready drops once the
// input register is full; a new byte is still taken while the result waits,
// as long as the input register is free or moving on.
// Reset clears both stages and the framing state: the block waits for the
// first line of a new reply, with the code and flag at zero.
module ftp_reply_framer (
  input  logic clk_i,
  input  logic rst_ni,
  ftpr_rx_if.sink      rx_i,
  ftpr_reply_if.source reply_o
);
  import ftpr_pkg::*;

  // input stage
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       adv;
  logic       fire;

  // framing state
  phase_e                         phase_q, phase_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic [PrefixLen-1:0][7:0]      chars_q, chars_d;
  logic [CodeW-1:0]               code_q, code_d, code_upd;
  logic                           ml_q, ml_d, ml_upd;

  // result stage
  logic             out_vld_q;
  status_e          status_q, status_c;
  logic [CodeW-1:0] code_out_q, code_out_c;
  logic             ml_out_q, ml_out_c;

  logic             is_sp, is_hy, is_nl;
  logic             prefix_ok;
  logic [CodeW-1:0] prefix_code;
  logic             cnt_full;

  assign adv        = !out_vld_q || reply_o.ready;
  assign fire       = in_vld_q && adv;
  assign rx_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  assign is_sp     = (in_byte_q == ChSpace);
  assign is_hy     = (in_byte_q == ChHyphen);
  assign is_nl     = (in_byte_q == ChNl);
  assign cnt_full  = (cnt_q == CntW'(PrefixLen));
  assign prefix_ok = is_digit(chars_q[0]) && is_digit(chars_q[1]) && is_digit(chars_q[2]);
  // digit value is the low nibble of an ASCII digit
  assign prefix_code = {chars_q[0][DigitW-1:0], chars_q[1][DigitW-1:0],
                        chars_q[2][DigitW-1:0]};

  // result of the current byte
  always_comb begin
    status_c = ST_BUSY;
    case (phase_q)
      PH_END: begin
        if (is_nl) status_c = ST_DONE;
      end
      PH_FIRST: begin
        if (cnt_full && !(prefix_ok && (is_sp || is_hy))) status_c = ST_ERROR;
      end
      default: status_c = ST_BUSY;
    endcase
    code_out_c = (status_c == ST_ERROR) ? '0 : code_upd;
    ml_out_c   = (status_c == ST_ERROR) ? 1'b0 : ml_upd;
  end

  // next framing state
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    chars_d  = chars_q;
    code_upd = code_q;
    ml_upd   = ml_q;
    case (phase_q)
      PH_LINE: begin
        if (!cnt_full) begin
          chars_d[cnt_q[1:0]] = in_byte_q;
          cnt_d = cnt_q + CntW'(1);
        end else begin
          phase_d = (prefix_ok && is_sp && (prefix_code == code_q)) ? PH_END : PH_SKIP;
          cnt_d   = '0;
        end
      end
      PH_SKIP: begin
        if (is_nl) begin
          phase_d = PH_LINE;
          cnt_d   = '0;
        end
      end
      PH_END: begin
        phase_d = phase_q;
      end
      default: begin
        if (!cnt_full) begin
          chars_d[cnt_q[1:0]] = in_byte_q;
          cnt_d = cnt_q + CntW'(1);
        end else if (prefix_ok && (is_sp || is_hy)) begin
          code_upd = prefix_code;
          ml_upd   = is_hy;
          phase_d  = is_sp ? PH_END : PH_SKIP;
          cnt_d    = '0;
        end
      end
    endcase
    code_d = code_upd;
    ml_d   = ml_upd;
    // a completed or rejected reply drops everything and waits for a new one
    if (status_c != ST_BUSY) begin
      phase_d = PH_FIRST;
      cnt_d   = '0;
      code_d  = '0;
      ml_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_FIRST;
      cnt_q     <= '0;
      code_q    <= '0;
      ml_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        code_q  <= code_d;
        ml_q    <= ml_d;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      chars_q    <= chars_d;
      status_q   <= status_c;
      code_out_q <= code_out_c;
      ml_out_q   <= ml_out_c;
    end
  end

  assign reply_o.valid         = out_vld_q;
  assign reply_o.status        = status_q;
  assign reply_o.code_hundreds = code_out_q[CodeW-1 -: DigitW];
  assign reply_o.code_tens     = code_out_q[DigitW +: DigitW];
  assign reply_o.code_units    = code_out_q[DigitW-1:0];
  assign reply_o.is_multiline  = ml_out_q;

endmodule

/* rtl/core/ftpr_checker.sv */
// Port-level checks for the FTP reply framer, bound to the top level.
`include "assert_macros.svh"

module ftpr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input ftpr_pkg::status_e status_i,
  input logic [3:0]        code_hundreds_i,
  input logic [3:0]        code_tens_i,
  input logic [3:0]        code_units_i,
  input logic              is_multiline_i
);
  import ftpr_pkg::*;

  `FTPR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(status_i) && $stable(code_hundreds_i) && $stable(code_tens_i)
    && $stable(code_units_i) && $stable(is_multiline_i), "reply beat changed while stalled")

  `FTPR_ASSERT_IMPL(a_err_clean, clk_i, rst_ni, out_valid_i && (status_i == ST_ERROR),
    (code_hundreds_i == 4'd0) && (code_tens_i == 4'd0) && (code_units_i == 4'd0)
    && !is_multiline_i, "error beat carries a code or flag")

  `FTPR_ASSERT_IMPL(a_digit_range, clk_i, rst_ni, out_valid_i,
    (code_hundreds_i <= 4'd9) && (code_tens_i <= 4'd9) && (code_units_i <= 4'd9),
    "code digit out of decimal range")

  `FTPR_ASSERT_IMPL(a_ml_has_code, clk_i, rst_ni, out_valid_i && is_multiline_i,
    status_i != ST_ERROR, "multi-line flag on an error beat")

endmodule

bind ftp_reply_framer ftpr_checker u_ftpr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (reply_o.valid),
  .out_ready_i     (reply_o.ready),
  .status_i        (reply_o.status),
  .code_hundreds_i (reply_o.code_hundreds),
  .code_tens_i     (reply_o.code_tens),
  .code_units_i    (reply_o.code_units),
  .is_multiline_i  (reply_o.is_multiline)
);
